// ===== rtl/pixel_density_quadrant_accumulator_assert.svh =====
// assertion macros for the pixel density quadrant accumulator
// expects clk and rst_n in the scope of each use; no other dependencies
`ifndef PIXEL_DENSITY_QUADRANT_ACCUMULATOR_ASSERT_SVH
`define PIXEL_DENSITY_QUADRANT_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PDQA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PDQA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDQA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define PDQA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/pdqa_pkg.sv =====
// shared constants, command codes and inter-module structs
// no dependencies
package pdqa_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int COL_POS_W = $clog2(MAX_COLS + 1);
    localparam int ROW_POS_W = $clog2(MAX_ROWS + 1);

    localparam int CMD_W     = 3;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 10;
    localparam int THR_W     = 8;
    localparam int CTR_W     = 10;
    localparam int CAP_W     = 21;
    localparam int COUNT_W   = 21;
    localparam int DELTA_W   = 22;
    localparam int EPOCH_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(128);
    localparam logic [CTR_W-1:0] CENTER_X_RESET  = CTR_W'(320);
    localparam logic [CTR_W-1:0] CENTER_Y_RESET  = CTR_W'(240);
    localparam logic [CAP_W-1:0] CAPACITY_RESET  = CAP_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME_START = 3'd0,
        CMD_PIXEL       = 3'd1,
        CMD_ROW_END     = 3'd2,
        CMD_FRAME_END   = 3'd3,
        CMD_READ_COL    = 3'd4,
        CMD_READ_ROW    = 3'd5
    } cmd_t;

    typedef logic [3:0][COUNT_W-1:0] quad_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [CAP_W-1:0]     data;
    } cfg_wr_t;

    // column histogram request, taken with each accepted beat
    typedef struct packed {
        logic              clear;
        logic              inc;
        logic [COL_AW-1:0] addr;
    } col_issue_t;

    typedef struct packed {
        logic sweeping;
        logic write_pend;
    } col_status_t;

    typedef struct packed {
        logic               we;
        logic [ROW_AW-1:0]  waddr;
        logic [DELTA_W-1:0] wdata;
        logic               re;
        logic [ROW_AW-1:0]  raddr;
    } row_port_t;

endpackage

// ===== rtl/pdqa_col_hist.sv =====
// column histogram memory: read-modify-write with a registered read, epoch tags
// for frame clears, clearing sweep after reset and on epoch wrap; uses pdqa_pkg
module pdqa_col_hist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  pdqa_pkg::col_issue_t         issue,
    output logic [pdqa_pkg::COUNT_W-1:0] bin_value,
    output pdqa_pkg::col_status_t        status
);
    import pdqa_pkg::*;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [COUNT_W-1:0] count;
    } col_entry_t;

    col_entry_t         mem [MAX_COLS];
    col_entry_t         rd_reg;
    col_entry_t         wd;
    logic               we;
    logic [COL_AW-1:0]  wa;

    logic               pend_reg;
    logic [COL_AW-1:0]  addr_reg;
    logic [EPOCH_W-1:0] tag_s1_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic               sweep_reg;
    logic [COL_AW-1:0]  sweep_addr_reg;

    // an entry from an older frame reads as zero
    assign bin_value = (rd_reg.tag == tag_s1_reg) ? rd_reg.count : '0;

    always_comb
    begin
        we = sweep_reg || pend_reg;
        wa = sweep_reg ? sweep_addr_reg : addr_reg;
        if (sweep_reg)
        begin
            wd.tag   = epoch_reg;
            wd.count = '0;
        end
        else
        begin
            wd.tag   = tag_s1_reg;
            wd.count = bin_value + 1'b1;
        end
        epoch_next = epoch_reg + 1'b1;
    end

    // write-first: a read of the entry being written sees the new value
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (accept)
        begin
            if (we && (wa == issue.addr))
            begin
                rd_reg <= wd;
            end
            else
            begin
                rd_reg <= mem[issue.addr];
            end
            addr_reg   <= issue.addr;
            tag_s1_reg <= epoch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            epoch_reg      <= '0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            pend_reg <= accept && issue.inc;
            if (accept && issue.clear)
            begin
                epoch_reg <= epoch_next;
                if (epoch_next == '0)
                begin
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                end
            end
            if (sweep_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == COL_AW'(MAX_COLS - 1))
                begin
                    sweep_reg <= 1'b0;
                end
            end
        end
    end

    assign status.sweeping   = sweep_reg;
    assign status.write_pend = pend_reg;

endmodule

// ===== rtl/pdqa_row_store.sv =====
// row delta memory, one write and one registered read per cycle
// uses pdqa_pkg
module pdqa_row_store (
    input  logic                         clk,
    input  pdqa_pkg::row_port_t          port,
    output logic [pdqa_pkg::DELTA_W-1:0] rd_data
);
    import pdqa_pkg::*;

    logic [DELTA_W-1:0] mem [MAX_ROWS];
    logic [DELTA_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            rd_reg <= mem[port.raddr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== rtl/pdqa_event_ctrl.sv =====
// event decode: config registers, positions, quadrant counts, entry budget,
// and the requests to both memories; uses pdqa_pkg
module pdqa_event_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pdqa_pkg::cfg_wr_t          cfg,
    input  logic                       accept,
    input  pdqa_pkg::cmd_t             cmd,
    input  logic [pdqa_pkg::PIX_W-1:0] pixel,
    input  logic [pdqa_pkg::IDX_W-1:0] index,
    output pdqa_pkg::col_issue_t       col_issue,
    output pdqa_pkg::row_port_t        row_port,
    output logic                       col_rd_ok,
    output logic                       row_rd_ok,
    output pdqa_pkg::quad_t            quads
);
    import pdqa_pkg::*;

    logic [THR_W-1:0]     thr_reg,   lat_thr_reg, lat_thr_next;
    logic [CTR_W-1:0]     cx_reg,    lat_cx_reg,  lat_cx_next;
    logic [CTR_W-1:0]     cy_reg,    lat_cy_reg,  lat_cy_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [COL_POS_W-1:0] col_pos_reg, col_pos_next;
    logic [ROW_POS_W-1:0] row_pos_reg, row_pos_next;
    logic [1:0]           qsel_reg, qsel_next, qsel_new;
    quad_t                quad_reg, quad_next;
    logic [DELTA_W-1:0]   prev_reg, prev_next;
    logic [CAP_W-1:0]     entries_reg, entries_next;
    logic [DELTA_W-1:0]   half;
    logic                 take;
    logic                 bright;
    logic                 col_in_range;
    logic                 row_in_range;

    always_comb
    begin
        lat_thr_next = lat_thr_reg;
        lat_cx_next  = lat_cx_reg;
        lat_cy_next  = lat_cy_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        qsel_next    = qsel_reg;
        quad_next    = quad_reg;
        prev_next    = prev_reg;
        entries_next = entries_reg;
        qsel_new     = qsel_reg;
        half         = '0;

        take         = entries_reg < cap_reg;
        bright       = pixel > lat_thr_reg;
        col_in_range = col_pos_reg < COL_POS_W'(MAX_COLS);
        row_in_range = row_pos_reg < ROW_POS_W'(MAX_ROWS);

        col_issue.clear = 1'b0;
        col_issue.inc   = 1'b0;
        col_issue.addr  = (cmd == CMD_READ_COL) ? COL_AW'(index) : COL_AW'(col_pos_reg);

        row_port.we    = 1'b0;
        row_port.waddr = ROW_AW'(row_pos_reg);
        row_port.wdata = '0;
        row_port.re    = accept;
        row_port.raddr = ROW_AW'(index);

        if (accept)
        begin
            unique case (cmd)
                CMD_FRAME_START:
                begin
                    col_issue.clear = 1'b1;
                    col_pos_next    = '0;
                    row_pos_next    = '0;
                    qsel_next       = '0;
                    quad_next       = '0;
                    prev_next       = '0;
                    entries_next    = '0;
                    lat_thr_next    = thr_reg;
                    lat_cx_next     = cx_reg;
                    lat_cy_next     = cy_reg;
                end
                CMD_PIXEL:
                begin
                    if (bright && take)
                    begin
                        entries_next = entries_reg + 1'b1;
                        qsel_new[0]  = !(int'(col_pos_reg) < int'(lat_cx_reg));
                        qsel_next    = qsel_new;
                        col_issue.inc = col_in_range;
                        quad_next[qsel_new] = quad_reg[qsel_new] + 1'b1;
                    end
                    if (col_in_range)
                    begin
                        col_pos_next = col_pos_reg + 1'b1;
                    end
                end
                CMD_ROW_END:
                begin
                    if (take)
                    begin
                        entries_next = entries_reg + 1'b1;
                        if (int'(row_pos_reg) < int'(lat_cy_reg))
                        begin
                            qsel_new[1] = 1'b0;
                            half = {1'b0, quad_reg[0]} + {1'b0, quad_reg[1]};
                        end
                        else
                        begin
                            qsel_new[1] = 1'b1;
                            half = {1'b0, quad_reg[2]} + {1'b0, quad_reg[3]};
                        end
                        qsel_next = qsel_new;
                        if (row_in_range)
                        begin
                            row_port.we    = 1'b1;
                            row_port.wdata = half - prev_reg;
                            row_pos_next   = row_pos_reg + 1'b1;
                        end
                        prev_next = half;
                        quad_next[qsel_new] = quad_reg[qsel_new] + 1'b1;
                    end
                    col_pos_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // rows below the fill mark were written in this frame
    assign col_rd_ok = int'(index) < MAX_COLS;
    assign row_rd_ok = int'(index) < int'(row_pos_reg);
    assign quads     = quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THRESHOLD_RESET;
            cx_reg      <= CENTER_X_RESET;
            cy_reg      <= CENTER_Y_RESET;
            cap_reg     <= CAPACITY_RESET;
            lat_thr_reg <= THRESHOLD_RESET;
            lat_cx_reg  <= CENTER_X_RESET;
            lat_cy_reg  <= CENTER_Y_RESET;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            qsel_reg    <= '0;
            quad_reg    <= '0;
            prev_reg    <= '0;
            entries_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_THRESHOLD: thr_reg <= cfg.data[THR_W-1:0];
                    REG_CENTER_X:  cx_reg  <= cfg.data[CTR_W-1:0];
                    REG_CENTER_Y:  cy_reg  <= cfg.data[CTR_W-1:0];
                    REG_CAPACITY:  cap_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            lat_thr_reg <= lat_thr_next;
            lat_cx_reg  <= lat_cx_next;
            lat_cy_reg  <= lat_cy_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            qsel_reg    <= qsel_next;
            quad_reg    <= quad_next;
            prev_reg    <= prev_next;
            entries_reg <= entries_next;
        end
    end

endmodule

// ===== rtl/pixel_density_quadrant_accumulator.sv =====
// top level: stream ports, result stage and output register
// depends on pdqa_pkg, pdqa_event_ctrl, pdqa_col_hist, pdqa_row_store

// Takes one camera event per cycle on the slave stream (command in s_tuser) while
// s_tready is high and returns one result beat for frame end, read column and
// read row through the result stage and the output register. The rate is set by
// the column histogram read-modify-write, which reads on the accepting edge and
// writes back on the next one with write-first forwarding, so consecutive pixels
// never wait. Frame clears of the column histogram use epoch tags and those of the
// row deltas a fill mark, so a frame start does not stall; after reset and on every
// 256th frame start a clearing pass over all MAX_COLS (1024) bins holds s_tready
// low while configuration writes are still taken. A stalled master side holds one
// result in the output register and one in the result stage before s_tready drops.
module pixel_density_quadrant_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // pixel[7:0], index[17:8], zero pad
    input  logic [2:0]                       s_tuser,   // command[2:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value[21:0], total[42:22], quad_top_left[63:43], quad_top_right[84:64],
    // quad_bottom_left[105:85], quad_bottom_right[126:106], zero pad
    output logic [127:0]                     m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pdqa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdqa_pkg::CAP_W-1:0]       cfg_data
);
    import pdqa_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] bottom_right;
        logic [COUNT_W-1:0] bottom_left;
        logic [COUNT_W-1:0] top_right;
        logic [COUNT_W-1:0] top_left;
        logic [COUNT_W-1:0] total;
        logic [DELTA_W-1:0] read_value;
    } result_t;

    cfg_wr_t            cfg;
    cmd_t               cmd;
    logic               accept;
    logic               advance;
    logic               out_free;
    col_issue_t         col_issue;
    col_status_t        col_status;
    row_port_t          row_port;
    logic               col_rd_ok;
    logic               row_rd_ok;
    quad_t              quads;
    logic [COUNT_W-1:0] bin_value;
    logic [DELTA_W-1:0] row_value;

    logic               s1_valid_reg;
    cmd_t               s1_kind_reg;
    logic               s1_ok_reg;
    logic               m_tvalid_reg;
    result_t            result_reg;
    result_t            result_next;

    assign cmd       = cmd_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = !s1_valid_reg || out_free;
    assign s_tready  = !col_status.sweeping && advance;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    pdqa_event_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .cmd       (cmd),
        .pixel     (s_tdata[7:0]),
        .index     (s_tdata[17:8]),
        .col_issue (col_issue),
        .row_port  (row_port),
        .col_rd_ok (col_rd_ok),
        .row_rd_ok (row_rd_ok),
        .quads     (quads)
    );

    pdqa_col_hist u_col_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .issue     (col_issue),
        .bin_value (bin_value),
        .status    (col_status)
    );

    pdqa_row_store u_row_store (
        .clk     (clk),
        .port    (row_port),
        .rd_data (row_value)
    );

    always_comb
    begin
        result_next = '0;
        unique case (s1_kind_reg)
            CMD_FRAME_END:
            begin
                result_next.total        = quads[0] + quads[1] + quads[2] + quads[3];
                result_next.top_left     = quads[0];
                result_next.top_right    = quads[1];
                result_next.bottom_left  = quads[2];
                result_next.bottom_right = quads[3];
            end
            CMD_READ_COL:
            begin
                if (s1_ok_reg)
                begin
                    result_next.read_value = {1'b0, bin_value};
                end
            end
            CMD_READ_ROW:
            begin
                if (s1_ok_reg)
                begin
                    result_next.read_value = row_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= cmd;
            s1_ok_reg   <= (cmd == CMD_READ_COL) ? col_rd_ok : row_rd_ok;
        end
        if (s1_valid_reg && out_free)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= accept && ((cmd == CMD_FRAME_END) ||
                                           (cmd == CMD_READ_COL) ||
                                           (cmd == CMD_READ_ROW));
            end
            if (s1_valid_reg && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};

`include "pixel_density_quadrant_accumulator_assert.svh"

    `PDQA_ASSERT_IMPLIES(a_sweep_no_rmw, col_status.sweeping, !col_status.write_pend, "histogram write during clearing pass")
    `PDQA_ASSERT_NEXT(a_result_held, s1_valid_reg && !out_free, s1_valid_reg, "pending result dropped under stall")
    `PDQA_ASSERT_NEXT(a_result_shown, s1_valid_reg && out_free, m_tvalid, "result stage moved without output beat")

endmodule

// ===== tb/sv/pixel_density_quadrant_accumulator_checker.sv =====
// checker for the pixel density quadrant accumulator: follows the stream and register
// channels, predicts every result beat and compares it field by field
// depends on pdqa_pkg
module pixel_density_quadrant_accumulator_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel[7:0], index[17:8], zero pad
    input  logic [2:0]                     s_tuser,   // command[2:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value[21:0], total[42:22], quad_top_left[63:43], quad_top_right[84:64],
    // quad_bottom_left[105:85], quad_bottom_right[126:106], zero pad
    input  logic [127:0]                   m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pdqa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdqa_pkg::CAP_W-1:0]     cfg_data,
    output int                             readouts_pending,
    output int                             failures,
    output int                             beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdqa_pkg::*;

    typedef struct packed {
        logic [DELTA_W-1:0] read_value;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] quad_tl;
        logic [COUNT_W-1:0] quad_tr;
        logic [COUNT_W-1:0] quad_bl;
        logic [COUNT_W-1:0] quad_br;
    } readout_t;

    // register file and the copies taken at frame start
    logic [THR_W-1:0]     thr_reg;
    logic [THR_W-1:0]     thr_live;
    logic [CTR_W-1:0]     cx_reg;
    logic [CTR_W-1:0]     cx_live;
    logic [CTR_W-1:0]     cy_reg;
    logic [CTR_W-1:0]     cy_live;
    logic [CAP_W-1:0]     cap_reg;

    logic [COL_POS_W-1:0] col_pos;
    logic [ROW_POS_W-1:0] row_pos;
    logic [1:0]           quad_sel;     // bit 0 right half, bit 1 bottom half
    logic [COUNT_W-1:0]   col_bins [MAX_COLS];
    logic [DELTA_W-1:0]   row_deltas [MAX_ROWS];
    logic [COUNT_W-1:0]   quad_cnt [4];
    logic [DELTA_W-1:0]   last_half;
    logic [CAP_W-1:0]     entries;

    readout_t expected_readouts[$];
    int       mismatch_count = 0;
    int       checked_count  = 0;

    task automatic clear_frame();
        col_pos   = '0;
        row_pos   = '0;
        quad_sel  = '0;
        last_half = '0;
        entries   = '0;
        for (int k = 0; k < MAX_COLS; k++) col_bins[k] = '0;
        for (int k = 0; k < MAX_ROWS; k++) row_deltas[k] = '0;
        for (int k = 0; k < 4; k++) quad_cnt[k] = '0;
    endtask

    function automatic bit take_entry();
        if (entries >= cap_reg) return 1'b0;
        entries = entries + 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic apply_event(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix,
                               input logic [IDX_W-1:0] idx);
        readout_t           r;
        logic [DELTA_W-1:0] half;
        r = '0;
        case (cmd)
            CMD_FRAME_START:
            begin
                clear_frame();
                thr_live = thr_reg;
                cx_live  = cx_reg;
                cy_live  = cy_reg;
            end
            CMD_PIXEL:
            begin
                if (pix > thr_live && take_entry())
                begin
                    quad_sel[0] = (col_pos >= cx_live);
                    if (col_pos < MAX_COLS)
                        col_bins[col_pos[COL_AW-1:0]] = col_bins[col_pos[COL_AW-1:0]] + 1'b1;
                    quad_cnt[quad_sel] = quad_cnt[quad_sel] + 1'b1;
                end
                // column position stops one past the last bin
                if (col_pos < MAX_COLS) col_pos = col_pos + 1'b1;
            end
            CMD_ROW_END:
            begin
                if (take_entry())
                begin
                    if (row_pos < cy_live)
                    begin
                        quad_sel[1] = 1'b0;
                        half = DELTA_W'(quad_cnt[0]) + DELTA_W'(quad_cnt[1]);
                    end
                    else
                    begin
                        quad_sel[1] = 1'b1;
                        half = DELTA_W'(quad_cnt[2]) + DELTA_W'(quad_cnt[3]);
                    end
                    if (row_pos < MAX_ROWS)
                    begin
                        row_deltas[row_pos[ROW_AW-1:0]] = half - last_half;
                        row_pos = row_pos + 1'b1;
                    end
                    last_half = half;
                    quad_cnt[quad_sel] = quad_cnt[quad_sel] + 1'b1;
                end
                col_pos = '0;
            end
            CMD_FRAME_END:
            begin
                r.total   = quad_cnt[0] + quad_cnt[1] + quad_cnt[2] + quad_cnt[3];
                r.quad_tl = quad_cnt[0];
                r.quad_tr = quad_cnt[1];
                r.quad_bl = quad_cnt[2];
                r.quad_br = quad_cnt[3];
                expected_readouts.push_back(r);
            end
            CMD_READ_COL:
            begin
                r.read_value = DELTA_W'(col_bins[idx]);
                expected_readouts.push_back(r);
            end
            CMD_READ_ROW:
            begin
                r.read_value = row_deltas[idx];
                expected_readouts.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic compare_readout(input logic [127:0] beat);
        readout_t want;
        if (expected_readouts.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", beat[31:0], '0);
        end
        else
        begin
            want = expected_readouts.pop_front();
            checked_count++;
            if (beat[21:0] !== want.read_value)
                report_mismatch("read_value", 32'(beat[21:0]), 32'(want.read_value));
            if (beat[42:22] !== want.total)
                report_mismatch("total", 32'(beat[42:22]), 32'(want.total));
            if (beat[63:43] !== want.quad_tl)
                report_mismatch("quad_top_left", 32'(beat[63:43]), 32'(want.quad_tl));
            if (beat[84:64] !== want.quad_tr)
                report_mismatch("quad_top_right", 32'(beat[84:64]), 32'(want.quad_tr));
            if (beat[105:85] !== want.quad_bl)
                report_mismatch("quad_bottom_left", 32'(beat[105:85]), 32'(want.quad_bl));
            if (beat[126:106] !== want.quad_br)
                report_mismatch("quad_bottom_right", 32'(beat[126:106]), 32'(want.quad_br));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  = THRESHOLD_RESET;
            cx_reg   = CENTER_X_RESET;
            cy_reg   = CENTER_Y_RESET;
            cap_reg  = CAPACITY_RESET;
            thr_live = thr_reg;
            cx_live  = cx_reg;
            cy_live  = cy_reg;
            clear_frame();
            expected_readouts.delete();
        end
        else
        begin
            // results leaving this edge come from older beats, so compare first
            if (m_tvalid && m_tready) compare_readout(m_tdata);
            if (s_tvalid && s_tready) apply_event(s_tuser, s_tdata[7:0], s_tdata[17:8]);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
                    REG_CENTER_X:  cx_reg  = cfg_data[CTR_W-1:0];
                    REG_CENTER_Y:  cy_reg  = cfg_data[CTR_W-1:0];
                    REG_CAPACITY:  cap_reg = cfg_data;
                    default: ;
                endcase
            end
        end
        readouts_pending <= expected_readouts.size();
        failures         <= mismatch_count;
        beats_checked    <= checked_count;
    end

endmodule

// ===== tb/sv/pixel_density_quadrant_accumulator_test.sv =====
// testbench top for the pixel density quadrant accumulator: clock, reset, stimulus
// and verdict; depends on pdqa_pkg, the block and pixel_density_quadrant_accumulator_checker
module pixel_density_quadrant_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pdqa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
    localparam logic [CAP_W-1:0] CAPACITY_MAX = CAP_W'(1048576);
    localparam int               CYCLE_LIMIT  = 500000;
    localparam int               PHASES       = 8;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // pixel[7:0], index[17:8], zero pad
    logic [2:0]           s_tuser   = '0;   // command[2:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [127:0]         m_tdata;          // read_value, total, four quadrants
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAP_W-1:0]     cfg_data  = '0;

    int readouts_pending;
    int failures;
    int beats_checked;

    int         tx_pct = 0;
    int         rx_pct = 0;
    logic       hold_go = 1'b0;
    int         cycle_count = 0;
    int         events_sent = 0;
    int         frames_started = 0;
    int         settings_used = 0;
    logic [7:0] cur_thr = THRESHOLD_RESET;

    pixel_density_quadrant_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_density_quadrant_accumulator_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .readouts_pending (readouts_pending),
        .failures         (failures),
        .beats_checked    (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // output side: random stalls, and one long hold-off so the block backs up
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99, 0) >= rx_pct);
            end
        end
    end

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix,
                              input logic [IDX_W-1:0] idx);
        while ($urandom_range(99, 0) < tx_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, idx, pix};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd <= CMD_READ_ROW) events_sent++;
        if (cmd == CMD_FRAME_START) frames_started++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] v;
        case ($urandom_range(3, 0))
            0:       v = $urandom_range(1, 0) ? 8'hff : 8'h00;
            1:       v = cur_thr + PIX_W'($urandom_range(2, 0)) - 8'd1;
            default: v = PIX_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_read(input int span);
        logic [IDX_W-1:0] idx;
        case ($urandom_range(9, 0))
            0:       idx = '1;
            1, 2:    idx = IDX_W'($urandom);
            default: idx = IDX_W'($urandom_range(span, 0));
        endcase
        send_event($urandom_range(1, 0) ? CMD_READ_COL : CMD_READ_ROW, PIX_W'($urandom), idx);
    endtask

    // any code including the unused ones, anywhere in a frame
    task automatic send_noise();
        send_event(CMD_W'($urandom_range(7, 0)), PIX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic run_frame(input int rows, input int cols);
        int ncols;
        send_event(CMD_FRAME_START, PIX_W'($urandom), IDX_W'($urandom));
        for (int r = 0; r < rows; r++)
        begin
            ncols = $urandom_range(cols, 0);
            for (int c = 0; c < ncols; c++)
            begin
                send_event(CMD_PIXEL, rand_pixel(), IDX_W'($urandom));
                if ($urandom_range(99, 0) < 4) send_noise();
                if ($urandom_range(99, 0) < 3) send_read(cols);
            end
            send_event(CMD_ROW_END, PIX_W'($urandom), IDX_W'($urandom));
        end
        if ($urandom_range(9, 0) != 0)
            send_event(CMD_FRAME_END, PIX_W'($urandom), IDX_W'($urandom));
        repeat ($urandom_range(3, 0)) send_read(cols > rows ? cols : rows);
    endtask

    task automatic configure(input logic [THR_W-1:0] thr, input logic [CTR_W-1:0] cx,
                             input logic [CTR_W-1:0] cy, input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{CAP_W'(thr), CAP_W'(cx), CAP_W'(cy), cap};
        regs = '{REG_THRESHOLD, REG_CENTER_X, REG_CENTER_Y, REG_CAPACITY};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_thr = thr;
        settings_used++;
    endtask

    // stop sending and let every predicted result come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readouts_pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, threshold 128
        send_event(CMD_FRAME_END, 8'h00, 10'd0);        // frame end with no frame start
        send_event(CMD_UNUSED_6, 8'hff, 10'h3ff);
        send_event(CMD_UNUSED_7, 8'h00, 10'h000);
        send_event(CMD_FRAME_START, 8'h00, 10'd0);
        send_event(CMD_PIXEL, 8'hff, 10'd0);            // bright pixel in column zero
        send_event(CMD_PIXEL, 8'h00, 10'd0);
        send_event(CMD_PIXEL, 8'd128, 10'd0);           // equal to threshold, not bright
        send_event(CMD_PIXEL, 8'd129, 10'h3ff);
        send_event(CMD_ROW_END, 8'h00, 10'd0);
        send_event(CMD_PIXEL, 8'd200, 10'd0);
        send_event(CMD_ROW_END, 8'hff, 10'h3ff);
        send_event(CMD_READ_COL, 8'h00, 10'd0);
        send_event(CMD_READ_COL, 8'h00, 10'd3);
        send_event(CMD_READ_COL, 8'hff, 10'h3ff);
        send_event(CMD_READ_ROW, 8'h00, 10'd0);
        send_event(CMD_READ_ROW, 8'h00, 10'd1);
        send_event(CMD_READ_ROW, 8'h00, 10'h3ff);
        send_event(CMD_FRAME_END, 8'h00, 10'd0);
        send_event(CMD_FRAME_START, 8'h00, 10'd0);
        send_event(CMD_FRAME_END, 8'h00, 10'd0);
        send_event(CMD_READ_COL, 8'h00, 10'd0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin tx_pct = 0;  rx_pct <= 0;  end
                1:       begin tx_pct = 52; rx_pct <= 0;  end
                2:       begin tx_pct = 0;  rx_pct <= 52; end
                default: begin tx_pct = 18; rx_pct <= 18; end
            endcase
            case (p)
                0: configure(8'd0, 10'd0, 10'd0, CAPACITY_MAX);
                1: configure(8'd255, 10'h3ff, 10'h3ff, CAP_W'(1));
                2: configure(THR_W'($urandom), CTR_W'($urandom_range(8, 0)),
                             CTR_W'($urandom_range(6, 0)), CAP_W'($urandom_range(40, 1)));
                4: configure(THR_W'($urandom), CTR_W'($urandom_range(5, 1)),
                             CTR_W'($urandom_range(4, 1)), CAP_W'($urandom_range(60, 5)));
                6: configure(8'd100, 10'd512, 10'd512, CAPACITY_MAX);
                default: configure(THR_W'($urandom), CTR_W'($urandom_range(8, 0)),
                                   CTR_W'($urandom_range(6, 0)),
                                   CAP_W'($urandom_range(1, 0) ? $urandom_range(80, 1)
                                                               : $urandom_range(1048576, 1)));
            endcase

            if (p == 2)
            begin
                // output held off while reads keep coming: the block fills and stalls
                hold_go <= 1'b1;
                repeat (40) send_read(8);
            end

            // enough short frames to carry the frame count past the clear-tag wrap
            if (p == 7)
                while (frames_started < 300)
                    run_frame($urandom_range(1, 0), $urandom_range(2, 0));

            target = events_sent + 70;
            while (events_sent < target)
            begin
                if (p == 5 && events_sent + 35 == target) settle();
                if ($urandom_range(9, 0) == 0)
                    send_noise();
                else if ($urandom_range(9, 0) < 4)
                    run_frame($urandom_range(1, 0), $urandom_range(2, 0));
                else
                    run_frame($urandom_range(6, 0), $urandom_range(8, 0));
            end
            settle();
        end

        rx_pct <= 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readouts_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d events in %0d frames under %0d register settings, %0d results",
                 events_sent, frames_started, settings_used, beats_checked);
        $display("including capacity limits, the clear-tag wrap and a long output stall");
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pdqa_pkg.sv
rtl/pdqa_col_hist.sv
rtl/pdqa_row_store.sv
rtl/pdqa_event_ctrl.sv
rtl/pixel_density_quadrant_accumulator.sv
tb/sv/pixel_density_quadrant_accumulator_checker.sv
tb/sv/pixel_density_quadrant_accumulator_test.sv
